@@ rtl/core/ldf_pkg.sv @@
// shared types, codes and helper functions of the luma deblocking edge filter
// no dependencies; imported by the channel interfaces and all modules

package ldf_pkg;

   localparam int SAMPLE_W = 8;
   localparam int WIDE_W   = 12;

   localparam logic [2:0] STRENGTH_NONE  = 3'd0;
   localparam logic [2:0] STRENGTH_INTRA = 3'd4;

   localparam logic signed [WIDE_W-1:0] SAMPLE_MAX = 12'sd255;

   typedef logic [SAMPLE_W-1:0]        sample_type;
   typedef logic signed [WIDE_W-1:0]   wide_type;

   typedef struct packed {
      sample_type  sample_p3;
      sample_type  sample_p2;
      sample_type  sample_p1;
      sample_type  sample_p0;
      sample_type  sample_q0;
      sample_type  sample_q1;
      sample_type  sample_q2;
      sample_type  sample_q3;
      logic [2:0]  strength;
      logic [7:0]  alpha_limit;
      logic [4:0]  beta_limit;
      logic [4:0]  clip_base;
   } ldf_req_type;

   typedef struct packed {
      sample_type  out_p2;
      sample_type  out_p1;
      sample_type  out_p0;
      sample_type  out_q0;
      sample_type  out_q1;
      sample_type  out_q2;
   } ldf_rsp_type;

   function automatic wide_type to_wide(input sample_type x);
      return $signed({4'b0000, x});
   endfunction

   function automatic sample_type abs_diff(input sample_type a, input sample_type b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   // clip to -lim..lim
   function automatic wide_type clip_sym(input wide_type v, input logic [5:0] lim);
      wide_type lim_s;
      lim_s = $signed({6'b000000, lim});
      if (v > lim_s) return lim_s;
      if (v < -lim_s) return -lim_s;
      return v;
   endfunction

   function automatic sample_type sat8(input wide_type v);
      if (v < 12'sd0) return '0;
      if (v > SAMPLE_MAX) return sample_type'(SAMPLE_MAX);
      return v[SAMPLE_W-1:0];
   endfunction

endpackage

@@ rtl/core/ldf_if.sv @@
// valid/ready channel interfaces for edge lines and filtered results
// depends on ldf_pkg for the payload structs

interface ldf_req_if import ldf_pkg::*; ();
   logic         valid;
   logic         ready;
   ldf_req_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ldf_rsp_if import ldf_pkg::*; ();
   logic         valid;
   logic         ready;
   ldf_rsp_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/ldf_datapath.sv @@
// combinational filter for one edge line: decisions, normal and intra filters
// depends on ldf_pkg for payload types and helpers

module ldf_datapath import ldf_pkg::*; (
   input  ldf_req_type  line,
   output ldf_rsp_type  result
);

   sample_type p3, p2, p1, p0, q0, q1, q2, q3;
   wide_type   p2s, p1s, p0s, q0s, q1s, q2s;
   logic       filt, apb, aqb, small_gap;
   logic [7:0] beta_ext, small_lim;

   wide_type   delta_raw, delta, delta_clip, avg;
   wide_type   p1_term, q1_term;
   logic [5:0] tc;

   logic [WIDE_W-1:0] sp0, sp1, sp2, sq0, sq1, sq2, wp0, wq0;
   ldf_rsp_type        normal_res, intra_res;

   assign p3 = line.sample_p3;
   assign p2 = line.sample_p2;
   assign p1 = line.sample_p1;
   assign p0 = line.sample_p0;
   assign q0 = line.sample_q0;
   assign q1 = line.sample_q1;
   assign q2 = line.sample_q2;
   assign q3 = line.sample_q3;

   assign p2s = to_wide(p2);
   assign p1s = to_wide(p1);
   assign p0s = to_wide(p0);
   assign q0s = to_wide(q0);
   assign q1s = to_wide(q1);
   assign q2s = to_wide(q2);

   assign beta_ext  = {3'b000, line.beta_limit};
   assign small_lim = {2'b00, line.alpha_limit[7:2]} + 8'd2;

   assign filt = (abs_diff(p0, q0) < line.alpha_limit) &&
                 (abs_diff(p1, p0) < beta_ext) && (abs_diff(q1, q0) < beta_ext);
   assign apb       = abs_diff(p2, p0) < beta_ext;
   assign aqb       = abs_diff(q2, q0) < beta_ext;
   assign small_gap = abs_diff(p0, q0) < small_lim;

   // normal filter, strengths one to three
   assign tc         = {1'b0, line.clip_base} + {5'b00000, apb} + {5'b00000, aqb};
   assign delta_raw  = ((q0s - p0s) <<< 2) + (p1s - q1s) + 12'sd4;
   assign delta      = delta_raw >>> 3;
   assign delta_clip = clip_sym(delta, tc);
   assign avg        = (p0s + q0s + 12'sd1) >>> 1;
   assign p1_term    = clip_sym((p2s + avg - (p1s <<< 1)) >>> 1, {1'b0, line.clip_base});
   assign q1_term    = clip_sym((q2s + avg - (q1s <<< 1)) >>> 1, {1'b0, line.clip_base});

   always_comb begin
      normal_res.out_p2 = p2;
      normal_res.out_q2 = q2;
      normal_res.out_p0 = sat8(p0s + delta_clip);
      normal_res.out_q0 = sat8(q0s - delta_clip);
      normal_res.out_p1 = apb ? sat8(p1s + p1_term) : p1;
      normal_res.out_q1 = aqb ? sat8(q1s + q1_term) : q1;
   end

   // intra filter, strong taps and weak three-tap fallback
   assign sp0 = 12'(p2) + (12'(p1) << 1) + (12'(p0) << 1) + (12'(q0) << 1) + 12'(q1) + 12'd4;
   assign sp1 = 12'(p2) + 12'(p1) + 12'(p0) + 12'(q0) + 12'd2;
   assign sp2 = (12'(p3) << 1) + 12'(p2) + (12'(p2) << 1) + 12'(p1) + 12'(p0)
                + 12'(q0) + 12'd4;
   assign sq0 = 12'(q2) + (12'(q1) << 1) + (12'(q0) << 1) + (12'(p0) << 1) + 12'(p1) + 12'd4;
   assign sq1 = 12'(q2) + 12'(q1) + 12'(q0) + 12'(p0) + 12'd2;
   assign sq2 = (12'(q3) << 1) + 12'(q2) + (12'(q2) << 1) + 12'(q1) + 12'(q0)
                + 12'(p0) + 12'd4;
   assign wp0 = (12'(p1) << 1) + 12'(p0) + 12'(q1) + 12'd2;
   assign wq0 = (12'(q1) << 1) + 12'(q0) + 12'(p1) + 12'd2;

   always_comb begin
      if (small_gap && apb) begin
         intra_res.out_p0 = sp0[10:3];
         intra_res.out_p1 = sp1[9:2];
         intra_res.out_p2 = sp2[10:3];
      end else begin
         intra_res.out_p0 = wp0[9:2];
         intra_res.out_p1 = p1;
         intra_res.out_p2 = p2;
      end
      if (small_gap && aqb) begin
         intra_res.out_q0 = sq0[10:3];
         intra_res.out_q1 = sq1[9:2];
         intra_res.out_q2 = sq2[10:3];
      end else begin
         intra_res.out_q0 = wq0[9:2];
         intra_res.out_q1 = q1;
         intra_res.out_q2 = q2;
      end
   end

   always_comb begin
      if (line.strength == STRENGTH_NONE || !filt) begin
         result.out_p2 = p2;
         result.out_p1 = p1;
         result.out_p0 = p0;
         result.out_q0 = q0;
         result.out_q1 = q1;
         result.out_q2 = q2;
      end else if (line.strength < STRENGTH_INTRA) begin
         result = normal_res;
      end else begin
         result = intra_res;
      end
   end

endmodule

@@ rtl/core/luma_deblock_edge_filter.sv @@
// luma deblocking filter for one line of eight samples across a block edge
//
// req_chan carries p3..q3 with strength, alpha, beta and tc0; rsp_chan returns
// the filtered p2..q2. both are valid/ready channels, a transaction moves when
// valid and ready are high at a rising clock edge.
// a request passes the input register, then the filter logic into the result
// register, whose output drives rsp_chan.valid and rsp_chan.payload.
// throughput: one line per cycle while the receiver keeps rsp_chan.ready high,
// set by the single pass through ldf_datapath between the two registers.
// when the receiver stalls the result register holds, the input register
// keeps filling, and req_chan.ready drops once both registers are full.
// strength zero or a failed edge test passes the samples through; strength
// four and above acts as intra.
// reset (synchronous, active high) empties both stages; no transaction is
// lost or repeated afterwards. depends on ldf_pkg, ldf_if and ldf_datapath.

module luma_deblock_edge_filter import ldf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ldf_req_if.sink     req_chan,
   ldf_rsp_if.source   rsp_chan
);

   logic         s1_valid_ff, s1_valid_in;
   logic         s2_valid_ff, s2_valid_in;
   ldf_req_type  line_ff;
   ldf_rsp_type  result_ff, result_comb;
   logic         s1_adv, s2_free, req_take;

   assign s2_free  = !s2_valid_ff || rsp_chan.ready;
   assign s1_adv   = s1_valid_ff && s2_free;
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready   = !s1_valid_ff || s2_free;
   assign rsp_chan.valid   = s2_valid_ff;
   assign rsp_chan.payload = result_ff;

   ldf_datapath u_datapath (
      .line   (line_ff),
      .result (result_comb)
   );

   assign s1_valid_in = req_take || (s1_valid_ff && !s1_adv);
   assign s2_valid_in = s1_adv || (s2_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         line_ff <= req_chan.payload;
      end
      if (s1_adv) begin
         result_ff <= result_comb;
      end
   end

`ifndef SYNTHESIS
   // an accepted line always lands in the input stage
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted line missing from input stage");

   // a line blocked by a full result stage holds its payload
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(line_ff)))
      else $error("stalled input stage lost its line");

   // strength zero passes the edge samples through unchanged
   assert property (@(posedge clock) disable iff (reset)
      (s1_adv && line_ff.strength == STRENGTH_NONE) |=>
         (result_ff.out_p0 == $past(line_ff.sample_p0) &&
          result_ff.out_q0 == $past(line_ff.sample_q0)))
      else $error("strength zero line was modified");

   // a result refused by the receiver stays valid
   assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !rsp_chan.ready) |=> s2_valid_ff)
      else $error("stalled result dropped");
`endif

endmodule

@@ sim/luma_deblock_edge_filter_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench of luma_deblock_edge_filter: directed and random edge lines
// with a built-in filter predictor; depends on ldf_pkg, ldf_if and the filter rtl

module luma_deblock_edge_filter_tb;
   import ldf_pkg::*;

   localparam int RANDOM_LINES = 980;
   localparam int STALL_LIMIT  = 5000;
   localparam int LONG_HOLD    = 60;
   localparam int DRAIN_CYCLES = 8;

   logic clock;
   logic reset;

   ldf_req_if req_chan ();
   ldf_rsp_if rsp_chan ();

   luma_deblock_edge_filter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   ldf_req_type line_queue[$];
   ldf_rsp_type expected_lines[$];

   int lines_taken;
   int total_lines;
   int results_checked;
   int mismatches;
   int stall_cycles;
   int hold_left;
   bit long_hold_done;
   int pass_lines, normal_lines, intra_lines;
   logic [1:0] phase;

   int send_idle_pct[3] = '{29, 64, 0};
   int recv_idle_pct[3] = '{64, 29, 0};
   string field_name[6] = '{"p2", "p1", "p0", "q0", "q1", "q2"};

   ldf_rsp_type want;
   logic [7:0] want_b, got_b;

   // idle pattern follows the number of lines taken so far
   assign phase = (lines_taken < total_lines / 3) ? 2'd0 :
                  (lines_taken < 2 * total_lines / 3) ? 2'd1 : 2'd2;

   function automatic int clamp_int(int lo, int hi, int v);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic int abs_gap(int a, int b);
      return (a > b) ? a - b : b - a;
   endfunction

   // expected p2..q2 for one edge line
   function automatic ldf_rsp_type filter_edge_line(ldf_req_type ln);
      int p3, p2, p1, p0, q0, q1, q2, q3;
      int alpha, beta, tc0, tc, delta, avg;
      int np2, np1, np0, nq0, nq1, nq2;
      bit gate_on, p_flat, q_flat, near_flat;
      ldf_rsp_type res;
      p3 = ln.sample_p3;  p2 = ln.sample_p2;  p1 = ln.sample_p1;  p0 = ln.sample_p0;
      q0 = ln.sample_q0;  q1 = ln.sample_q1;  q2 = ln.sample_q2;  q3 = ln.sample_q3;
      alpha = ln.alpha_limit;
      beta  = ln.beta_limit;
      tc0   = ln.clip_base;
      np2 = p2;  np1 = p1;  np0 = p0;  nq0 = q0;  nq1 = q1;  nq2 = q2;
      gate_on = abs_gap(p0, q0) < alpha && abs_gap(p1, p0) < beta && abs_gap(q1, q0) < beta;
      p_flat  = abs_gap(p2, p0) < beta;
      q_flat  = abs_gap(q2, q0) < beta;
      if (ln.strength != STRENGTH_NONE && gate_on) begin
         if (ln.strength < STRENGTH_INTRA) begin
            tc    = tc0 + int'(p_flat) + int'(q_flat);
            delta = clamp_int(-tc, tc, ((q0 - p0) * 4 + (p1 - q1) + 4) >>> 3);
            avg   = (p0 + q0 + 1) >>> 1;
            np0   = p0 + delta;
            nq0   = q0 - delta;
            if (p_flat) np1 = p1 + clamp_int(-tc0, tc0, (p2 + avg - 2 * p1) >>> 1);
            if (q_flat) nq1 = q1 + clamp_int(-tc0, tc0, (q2 + avg - 2 * q1) >>> 1);
         end else begin
            near_flat = abs_gap(p0, q0) < ((alpha >>> 2) + 2);
            if (near_flat && p_flat) begin
               np0 = (p2 + 2 * p1 + 2 * p0 + 2 * q0 + q1 + 4) >>> 3;
               np1 = (p2 + p1 + p0 + q0 + 2) >>> 2;
               np2 = (2 * p3 + 3 * p2 + p1 + p0 + q0 + 4) >>> 3;
            end else begin
               np0 = (2 * p1 + p0 + q1 + 2) >>> 2;
            end
            if (near_flat && q_flat) begin
               nq0 = (q2 + 2 * q1 + 2 * q0 + 2 * p0 + p1 + 4) >>> 3;
               nq1 = (q2 + q1 + q0 + p0 + 2) >>> 2;
               nq2 = (2 * q3 + 3 * q2 + q1 + q0 + p0 + 4) >>> 3;
            end else begin
               nq0 = (2 * q1 + q0 + p1 + 2) >>> 2;
            end
         end
      end
      res.out_p2 = 8'(clamp_int(0, 255, np2));
      res.out_p1 = 8'(clamp_int(0, 255, np1));
      res.out_p0 = 8'(clamp_int(0, 255, np0));
      res.out_q0 = 8'(clamp_int(0, 255, nq0));
      res.out_q1 = 8'(clamp_int(0, 255, nq1));
      res.out_q2 = 8'(clamp_int(0, 255, nq2));
      return res;
   endfunction

   function automatic ldf_req_type edge_line(int p3, int p2, int p1, int p0, int q0, int q1,
                                             int q2, int q3, int bs, int alpha, int beta,
                                             int tc0);
      ldf_req_type ln;
      ln.sample_p3 = 8'(p3);  ln.sample_p2 = 8'(p2);
      ln.sample_p1 = 8'(p1);  ln.sample_p0 = 8'(p0);
      ln.sample_q0 = 8'(q0);  ln.sample_q1 = 8'(q1);
      ln.sample_q2 = 8'(q2);  ln.sample_q3 = 8'(q3);
      ln.strength    = 3'(bs);
      ln.alpha_limit = 8'(alpha);
      ln.beta_limit  = 5'(beta);
      ln.clip_base   = 5'(tc0);
      return ln;
   endfunction

   function automatic int jitter(int center, int spread);
      int off;
      off = $urandom_range(0, 2 * spread);
      return clamp_int(0, 255, center + off - spread);
   endfunction

   // mostly smooth lines so the edge tests pass often, some lines of pure noise
   function automatic ldf_req_type random_line();
      int r, bs, alpha, beta, tc0, jump;
      int p0, p1, p2, p3, q0, q1, q2, q3;
      r = $urandom_range(0, 15);
      bs = (r < 2) ? 0 : (r < 9) ? $urandom_range(1, 3) : (r < 14) ? 4 : $urandom_range(5, 7);
      alpha = $urandom_range(0, 255);
      beta  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 18);
      tc0   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 25);
      if ($urandom_range(0, 4) == 0)
         return edge_line($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 7), alpha, $urandom_range(0, 31),
                          $urandom_range(0, 31));
      jump = $urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom_range(0, 40);
      p0 = $urandom_range(0, 255);
      q0 = jitter(p0, jump);
      p1 = jitter(p0, beta);
      q1 = jitter(q0, beta);
      p2 = jitter(p0, beta + 2);
      q2 = jitter(q0, beta + 2);
      p3 = jitter(p2, 8);
      q3 = jitter(q2, 8);
      return edge_line(p3, p2, p1, p0, q0, q1, q2, q3, bs, alpha, beta, tc0);
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // input side: offer queued lines, predict each accepted one
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_lines.push_back(filter_edge_line(req_chan.payload));
            lines_taken <= lines_taken + 1;
            if (req_chan.payload.strength == STRENGTH_NONE) pass_lines <= pass_lines + 1;
            else if (req_chan.payload.strength < STRENGTH_INTRA)
               normal_lines <= normal_lines + 1;
            else intra_lines <= intra_lines + 1;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (line_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct[phase]) begin
               req_chan.valid   <= 1'b1;
               req_chan.payload <= line_queue.pop_front();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // output side: compare each result with the oldest prediction, random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_checked <= results_checked + 1;
            if (expected_lines.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10)
                  $display("%0t: result with nothing expected: %h", $realtime,
                           rsp_chan.payload);
            end else begin
               want = expected_lines.pop_front();
               for (int k = 0; k < 6; k++) begin
                  want_b = want[47 - 8 * k -: 8];
                  got_b  = rsp_chan.payload[47 - 8 * k -: 8];
                  if (want_b !== got_b) begin
                     mismatches = mismatches + 1;
                     if (mismatches <= 10)
                        $display("%0t: out_%s expected %0d got %0d", $realtime,
                                 field_name[k], want_b, got_b);
                  end
               end
            end
         end
         if (hold_left != 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left      <= hold_left - 1;
         end else if (phase == 2'd2 && !long_hold_done) begin
            // long hold while the sender keeps offering, so both stages fill up
            rsp_chan.ready <= 1'b0;
            hold_left      <= LONG_HOLD - 1;
            long_hold_done <= 1'b1;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct[phase]);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      bit timed_out;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
      lines_taken = 0;  results_checked = 0;  mismatches = 0;  stall_cycles = 0;
      pass_lines = 0;  normal_lines = 0;  intra_lines = 0;
      long_hold_done = 1'b0;
      timed_out = 1'b0;

      // extremes and strengths zero to four
      line_queue.push_back(edge_line(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      line_queue.push_back(edge_line(255, 255, 255, 255, 255, 255, 255, 255, 7, 255, 31, 31));
      line_queue.push_back(edge_line(100, 102, 104, 106, 110, 112, 114, 116, 0, 40, 10, 4));
      line_queue.push_back(edge_line(100, 102, 104, 106, 110, 112, 114, 116, 1, 40, 10, 4));
      line_queue.push_back(edge_line(100, 102, 104, 106, 110, 112, 114, 116, 2, 40, 10, 4));
      line_queue.push_back(edge_line(100, 102, 104, 106, 110, 112, 114, 116, 3, 40, 10, 4));
      line_queue.push_back(edge_line(100, 102, 104, 106, 110, 112, 114, 116, 4, 40, 10, 4));
      // intra: weak on both sides, strong on p only
      line_queue.push_back(edge_line(90, 95, 98, 100, 130, 132, 135, 140, 4, 60, 6, 3));
      line_queue.push_back(edge_line(100, 100, 101, 102, 104, 105, 120, 121, 4, 40, 6, 3));
      line_queue.push_back(edge_line(90, 95, 98, 100, 130, 132, 135, 140, 5, 60, 6, 3));
      line_queue.push_back(edge_line(100, 100, 101, 102, 104, 105, 120, 121, 6, 40, 6, 3));
      // edge test fails on alpha, on the p side, on the q side
      line_queue.push_back(edge_line(100, 100, 100, 100, 120, 120, 120, 120, 2, 20, 10, 5));
      line_queue.push_back(edge_line(90, 90, 90, 100, 102, 102, 102, 102, 2, 40, 10, 5));
      line_queue.push_back(edge_line(100, 100, 100, 100, 102, 112, 112, 112, 2, 40, 10, 5));
      // saturation at both ends of the sample range
      line_queue.push_back(edge_line(0, 0, 0, 5, 0, 30, 30, 30, 3, 255, 31, 31));
      line_queue.push_back(edge_line(255, 255, 255, 250, 255, 225, 225, 225, 3, 255, 31, 31));
      // zero tc0 with both sides flat, zero beta
      line_queue.push_back(edge_line(100, 102, 104, 106, 110, 112, 114, 116, 1, 40, 10, 0));
      line_queue.push_back(edge_line(100, 100, 100, 100, 100, 100, 100, 100, 4, 40, 0, 9));
      line_queue.push_back(edge_line(60, 70, 80, 90, 95, 105, 115, 125, 3, 255, 18, 25));
      // alternating bit patterns
      line_queue.push_back(edge_line(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55,
                                     3'b101, 8'hAA, 5'h15, 5'h0A));
      line_queue.push_back(edge_line(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA,
                                     3'b010, 8'h55, 5'h0A, 5'h15));
      for (int i = 0; i < RANDOM_LINES; i++)
         line_queue.push_back(random_line());
      total_lines = line_queue.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (line_queue.size() != 0 || req_chan.valid || expected_lines.size() != 0) begin
         @(posedge clock);
         if (stall_cycles >= STALL_LIMIT) begin
            timed_out = 1'b1;
            break;
         end
      end

      if (timed_out) begin
         $display("timeout: no transaction for %0d cycles, %0d lines still expected",
                  STALL_LIMIT, expected_lines.size());
         $display("DONE: errors detected");
      end else begin
         repeat (DRAIN_CYCLES) @(posedge clock);
         $display("filtered %0d edge lines (%0d pass-through, %0d normal, %0d intra),",
                  lines_taken, pass_lines, normal_lines, intra_lines);
         $display("%0d results checked under mixed stalls and one long output hold",
                  results_checked);
         if (mismatches == 0 && expected_lines.size() == 0)
            $display("DONE: 0 errors");
         else
            $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
